FILE: sv/id3u_pkg.sv
// ----------------------------------------------------------------------------
// id3u_pkg
// Shared types and constants for the ID3v2 text to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package id3u_pkg;

	// text encoding modes, as kept in the per-text state
	localparam logic [1:0] ENC_LATIN1  = 2'd0;
	localparam logic [1:0] ENC_UTF16LE = 2'd1;
	localparam logic [1:0] ENC_UTF16BE = 2'd2;
	localparam logic [1:0] ENC_UTF8    = 2'd3;

	// encoding byte values
	localparam logic [7:0] ENCB_LATIN1 = 8'd0;
	localparam logic [7:0] ENCB_UTF16BE = 8'd2;
	localparam logic [7:0] ENCB_UTF8   = 8'd3;

	localparam logic [11:0] CAP_RESET = 12'd256;

	localparam logic [7:0]  BOM_FF  = 8'hFF;
	localparam logic [7:0]  BOM_FE  = 8'hFE;
	localparam logic [15:0] SURR_LO = 16'hD800;
	localparam logic [15:0] SURR_HI = 16'hDFFF;
	localparam logic [15:0] CP_2B   = 16'h0080;
	localparam logic [15:0] CP_3B   = 16'h0800;

	// per-text decode state
	typedef struct packed {
		logic [1:0]  mode;
		logic        big_endian;
		logic [1:0]  pos;
		logic [7:0]  held;
		logic        have_held;
		logic        stopped;
		logic [11:0] wc;
	} state_t;

	// all results of one input word: up to three UTF-8 bytes, then terminator
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      nbytes;
		logic            term;
		logic [11:0]     base;
	} run_t;

endpackage

FILE: sv/id3u_decode.sv
// ----------------------------------------------------------------------------
// id3u_decode
// Decodes one payload byte against the per-text state: next state and the
// run of UTF-8 bytes plus optional terminator that the byte produces.
// ----------------------------------------------------------------------------
module id3u_decode (
	input  logic [7:0]       data_byte,
	input  logic             first_byte,
	input  logic             last_byte,
	input  logic [11:0]      capacity,
	input  id3u_pkg::state_t cur,
	output id3u_pkg::state_t nxt,
	output id3u_pkg::run_t   run
);

	logic [15:0] cp;
	logic        want;
	logic [1:0]  k;
	logic [7:0]  b0, b1, b2;
	logic [12:0] need;

	always_comb begin
		nxt  = cur;
		run  = '0;
		run.base = cur.wc;
		cp   = '0;
		want = 1'b0;
		k    = 2'd0;
		b0   = '0;
		b1   = '0;
		b2   = '0;
		need = '0;

		if (first_byte) begin
			if (data_byte == id3u_pkg::ENCB_LATIN1) begin
				nxt.mode = id3u_pkg::ENC_LATIN1;
			end else if (data_byte == id3u_pkg::ENCB_UTF8) begin
				nxt.mode = id3u_pkg::ENC_UTF8;
			end else if (data_byte == id3u_pkg::ENCB_UTF16BE) begin
				nxt.mode = id3u_pkg::ENC_UTF16BE;
			end else begin
				nxt.mode = id3u_pkg::ENC_UTF16LE;
			end
			nxt.big_endian = (nxt.mode == id3u_pkg::ENC_UTF16BE);
			nxt.pos       = 2'd0;
			nxt.held      = '0;
			nxt.have_held = 1'b0;
			nxt.stopped   = 1'b0;
			nxt.wc        = '0;
			run.base      = '0;
		end else if (!cur.stopped) begin
			if (cur.pos != 2'd3)
				nxt.pos = cur.pos + 2'd1;
			if (cur.mode == id3u_pkg::ENC_LATIN1 || cur.mode == id3u_pkg::ENC_UTF8) begin
				if (data_byte == 8'd0) begin
					nxt.stopped = 1'b1;
				end else if (cur.mode == id3u_pkg::ENC_LATIN1 && data_byte[7]) begin
					want = 1'b1;
					k    = 2'd2;
					b0   = {6'b110000, data_byte[7:6]};
					b1   = {2'b10, data_byte[5:0]};
				end else begin
					want = 1'b1;
					k    = 2'd1;
					b0   = data_byte;
				end
			end else if (!cur.have_held) begin
				nxt.held      = data_byte;
				nxt.have_held = 1'b1;
			end else begin
				nxt.have_held = 1'b0;
				if (cur.pos == 2'd1 && cur.held == id3u_pkg::BOM_FF
						&& data_byte == id3u_pkg::BOM_FE) begin
					nxt.big_endian = 1'b0;
				end else if (cur.pos == 2'd1 && cur.held == id3u_pkg::BOM_FE
						&& data_byte == id3u_pkg::BOM_FF) begin
					nxt.big_endian = 1'b1;
				end else begin
					cp = cur.big_endian ? {cur.held, data_byte} : {data_byte, cur.held};
					if (cp == 16'd0 || (cp >= id3u_pkg::SURR_LO && cp <= id3u_pkg::SURR_HI)) begin
						nxt.stopped = 1'b1;
					end else if (cp < id3u_pkg::CP_2B) begin
						want = 1'b1;
						k    = 2'd1;
						b0   = cp[7:0];
					end else if (cp < id3u_pkg::CP_3B) begin
						want = 1'b1;
						k    = 2'd2;
						b0   = {3'b110, cp[10:6]};
						b1   = {2'b10, cp[5:0]};
					end else begin
						want = 1'b1;
						k    = 2'd3;
						b0   = {4'b1110, cp[15:12]};
						b1   = {2'b10, cp[11:6]};
						b2   = {2'b10, cp[5:0]};
					end
				end
			end

			// capacity check counts the terminator slot
			if (want) begin
				need = {1'b0, cur.wc} + {11'd0, k};
				if (need >= {1'b0, capacity}) begin
					nxt.stopped = 1'b1;
				end else begin
					run.bytes  = {b2, b1, b0};
					run.nbytes = k;
					nxt.wc     = need[11:0];
				end
			end
		end

		if (last_byte) begin
			nxt.stopped   = 1'b1;
			nxt.have_held = 1'b0;
			run.term      = 1'b1;
		end
	end

endmodule

FILE: sv/id3u_run_buf.sv
// ----------------------------------------------------------------------------
// id3u_run_buf
// Holds the results of one input word and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module id3u_run_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  id3u_pkg::run_t   run_in,
	output logic             space,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             terminator,
	output logic [11:0]      out_length,
	output logic             run_last
);

	id3u_pkg::run_t run_q;
	logic           valid_q;
	logic [1:0]     idx_q;
	logic [1:0]     last_idx;
	logic           is_term;
	logic           take;

	// result count is nbytes + term, at least one when loaded
	assign last_idx = run_q.nbytes - {1'b0, ~run_q.term};
	assign is_term  = run_q.term && (idx_q == run_q.nbytes);
	assign take     = valid_q && out_ready;
	assign space    = !valid_q || (out_ready && idx_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (idx_q == last_idx) begin
				valid_q <= 1'b0;
				idx_q   <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			run_q <= run_in;
	end

	always_comb begin
		case (idx_q)
			2'd0:    out_byte = run_q.bytes[0];
			2'd1:    out_byte = run_q.bytes[1];
			2'd2:    out_byte = run_q.bytes[2];
			default: out_byte = 8'd0;
		endcase
		if (is_term)
			out_byte = 8'd0;
	end

	assign out_valid  = valid_q;
	assign terminator = is_term;
	assign run_last   = (idx_q == last_idx);
	assign out_length = is_term ? (run_q.base + {10'd0, run_q.nbytes})
	                            : (run_q.base + {10'd0, idx_q} + 12'd1);

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q <= last_idx))
		else $error("run index past last result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && $stable(idx_q)))
		else $error("run advanced while stalled");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> space)
		else $error("run loaded over pending results");

	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (run_in.term || run_in.nbytes != 2'd0))
		else $error("empty run loaded");

endmodule

FILE: sv/id3_text_to_utf8_transcoder_unit.sv
// ----------------------------------------------------------------------------
// id3_text_to_utf8_transcoder_unit
// ID3v2 text frame payload bytes in, UTF-8 bytes plus terminator out.
// ----------------------------------------------------------------------------
//
//   channel | signals                                     | dir
//   --------+---------------------------------------------+-----
//   in      | in_valid in_ready data_byte first_byte      | in
//           | last_byte                                   |
//   out     | out_valid out_ready out_byte terminator     | out
//           | out_length run_last                         |
//   cfg     | cfg_valid cfg_ready cfg_data (out_capacity) | in
//
// One input word is decoded in the cycle it is accepted; its zero to four
// results are registered in the run buffer and leave one per cycle while
// out_ready is high. A word with at most one result then sustains one word
// per cycle; a word with more results holds the input until all of them
// have left through the single output port. Input is taken again in the
// cycle the last pending result leaves. Reset clears state and capacity
// goes to 256; no clearing pass. cfg_ready is always high.
// ----------------------------------------------------------------------------
module id3_text_to_utf8_transcoder_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        terminator,
	output logic [11:0] out_length,
	output logic        run_last,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data
);

	id3u_pkg::state_t state_q;
	id3u_pkg::state_t state_nxt;
	id3u_pkg::run_t   run;
	logic [11:0]      capacity_q;
	logic             space;
	logic             accept;
	logic             load;

	assign cfg_ready = 1'b1;
	assign in_ready  = space;
	assign accept    = in_valid && space;
	// words that produce nothing update state only
	assign load      = accept && (run.term || run.nbytes != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= id3u_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	id3u_decode u_decode (
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.capacity   (capacity_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.run        (run)
	);

	id3u_run_buf u_run_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.run_in     (run),
		.space      (space),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.terminator (terminator),
		.out_length (out_length),
		.run_last   (run_last)
	);

	// a last word always closes the text
	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (state_q.stopped && !state_q.have_held))
		else $error("text not stopped after last word");

	// written count never reaches capacity once anything was written
	a_wc_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !first_byte && run.nbytes != 2'd0)
		|=> ({1'b0, state_q.wc} < {1'b0, capacity_q}))
		else $error("written count reached capacity");

	// encoding word resets the count
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && first_byte) |=> (state_q.wc == 12'd0))
		else $error("count not cleared by encoding word");

endmodule

FILE: verif/id3_text_to_utf8_transcoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id3_text_to_utf8_transcoder_unit_tb
// Self-checking bench for the ID3v2 text to UTF-8 transcoder.
// A directed list of texts, then random well-formed ID3 texts mixed with
// noise, streamed under several output capacities. A local transcoder model
// predicts every UTF-8 word and terminator. Both sides idle at random, one
// long output stall backs the block up, and one item waits for a full drain.
// ----------------------------------------------------------------------------
module id3_text_to_utf8_transcoder_unit_tb;

	localparam logic [7:0] ENCB_UTF16 = 8'h01;	// UTF-16 with BOM, LE default
	localparam int unsigned SETTLE_CYCLES  = 8;	// settle time once all results are in
	localparam int unsigned RX_HOLD_CYCLES = 60;
	localparam int unsigned IDLE_LIMIT     = 2000;
	localparam int unsigned ITEM_TARGET    = 410;
	localparam int unsigned NUM_PHASES     = 9;
	localparam int unsigned TEXT_OVERRUN   = 10;	// words a phase runs past its mark

	// one input word, plus the sender's pacing for it
	typedef struct {
		logic [7:0]  data;
		logic        first;
		logic        last;
		int unsigned gap;	// idle cycles after this word is taken
		bit          drain;	// hold this word back until all results are in
	} frame_byte_t;

	// one output word
	typedef struct {
		logic [7:0]  code;
		logic        term;
		logic [11:0] length;
		logic        run_end;
	} utf8_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        terminator;
	logic [11:0] out_length;
	logic        run_last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [11:0] cfg_data = 12'd0;

	id3_text_to_utf8_transcoder_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.terminator (terminator),
		.out_length (out_length),
		.run_last   (run_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Transcoder model state (mirrors the block's per-text registers)
	// ------------------------------------------------------------------
	logic [11:0] t_cap  = id3u_pkg::CAP_RESET;
	logic [1:0]  t_mode = id3u_pkg::ENC_LATIN1;
	logic        t_be   = 1'b0;
	logic [1:0]  t_pos  = 2'd0;
	logic [7:0]  t_held = 8'h00;
	logic        t_have = 1'b0;
	logic        t_stop = 1'b0;
	logic [11:0] t_wc   = 12'd0;

	frame_byte_t payload_q[$];	// words waiting for the sender
	utf8_word_t  pending_utf8_q[$];	// predicted words not yet seen
	utf8_word_t  run_q[$];		// words of the input being modeled

	// bench bookkeeping
	int unsigned mismatches = 0;
	int unsigned items_queued = 0;
	int unsigned texts_queued = 0;
	int unsigned words_checked = 0;
	int unsigned idle_cycles = 0;
	int unsigned rx_holds_asked = 0;
	int unsigned rx_holds_done = 0;
	int unsigned drains_asked = 0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	bit          tx_burst = 1'b0;	// no sender gaps
	bit          rx_burst = 1'b0;	// no receiver stalls
	bit          tx_drain_next = 1'b0;
	logic        in_fire = 1'b0;
	logic        out_fire = 1'b0;

	// A character of k bytes goes out only while count + k < capacity.
	task automatic put_char(input int unsigned k, input logic [23:0] bytes);
		utf8_word_t w;
		int unsigned i;
		if ({20'd0, t_wc} + k >= {20'd0, t_cap}) begin
			t_stop = 1'b1;
		end else begin
			for (i = 0; i < k; i++) begin
				t_wc = t_wc + 12'd1;
				w.code    = bytes[23 - 8 * i -: 8];
				w.term    = 1'b0;
				w.length  = t_wc;
				w.run_end = 1'b0;
				run_q.push_back(w);
			end
		end
	endtask

	task automatic put_unit(input logic [15:0] u);
		if (u == 16'h0000 || (u >= id3u_pkg::SURR_LO && u <= id3u_pkg::SURR_HI))
			t_stop = 1'b1;	// zero char or surrogate ends the text
		else if (u < id3u_pkg::CP_2B)
			put_char(1, {u[7:0], 16'h0000});
		else if (u < id3u_pkg::CP_3B)
			put_char(2, {8'hC0 | u[10:6], 8'h80 | u[5:0], 8'h00});
		else
			put_char(3, {8'hE0 | u[15:12], 8'h80 | u[11:6], 8'h80 | u[5:0]});
	endtask

	// Model one accepted input word, append its results to the due list.
	task automatic transcode_byte(input logic [7:0] c, input logic first,
			input logic last);
		utf8_word_t w;
		logic [1:0]  pos;
		logic [7:0]  h;
		int unsigned i;
		run_q.delete();
		if (first) begin
			case (c)
			id3u_pkg::ENCB_LATIN1:  t_mode = id3u_pkg::ENC_LATIN1;
			id3u_pkg::ENCB_UTF8:    t_mode = id3u_pkg::ENC_UTF8;
			id3u_pkg::ENCB_UTF16BE: t_mode = id3u_pkg::ENC_UTF16BE;
			default:                t_mode = id3u_pkg::ENC_UTF16LE;
			endcase
			t_be   = (t_mode == id3u_pkg::ENC_UTF16BE);
			t_pos  = 2'd0;
			t_held = 8'h00;
			t_have = 1'b0;
			t_stop = 1'b0;
			t_wc   = 12'd0;
		end else if (!t_stop) begin
			pos = t_pos;
			if (t_pos != 2'd3)
				t_pos = t_pos + 2'd1;
			if (t_mode == id3u_pkg::ENC_LATIN1 || t_mode == id3u_pkg::ENC_UTF8) begin
				if (c == 8'h00)
					t_stop = 1'b1;
				else if (t_mode == id3u_pkg::ENC_LATIN1 && c[7])
					put_char(2, {8'hC0 | (c >> 6), 8'h80 | c[5:0], 8'h00});
				else
					put_char(1, {c, 16'h0000});
			end else if (!t_have) begin
				t_held = c;
				t_have = 1'b1;
			end else begin
				h = t_held;
				t_have = 1'b0;
				// a BOM only counts as the first unit of the text
				if (pos == 2'd1 && h == id3u_pkg::BOM_FF && c == id3u_pkg::BOM_FE)
					t_be = 1'b0;
				else if (pos == 2'd1 && h == id3u_pkg::BOM_FE && c == id3u_pkg::BOM_FF)
					t_be = 1'b1;
				else
					put_unit(t_be ? {h, c} : {c, h});
			end
		end
		if (last) begin
			t_stop = 1'b1;
			t_have = 1'b0;	// odd trailing byte is dropped
			w.code    = 8'h00;
			w.term    = 1'b1;
			w.length  = t_wc;
			w.run_end = 1'b0;
			run_q.push_back(w);
		end
		for (i = 0; i < run_q.size(); i++) begin
			w = run_q[i];
			w.run_end = (i == run_q.size() - 1);
			pending_utf8_q.push_back(w);
		end
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
				$time, what, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: check the output word first, then model the input word
	// taken at the same edge (its results can only show up later).
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		utf8_word_t w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_utf8_q.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, got byte 0x%0h term %0b len %0d",
						$time, out_byte, terminator, out_length);
					mismatches++;
				end else begin
					w = pending_utf8_q.pop_front();
					check_field("out_byte", 32'(w.code), 32'(out_byte));
					check_field("terminator", 32'(w.term), 32'(terminator));
					check_field("out_length", 32'(w.length), 32'(out_length));
					check_field("run_last", 32'(w.run_end), 32'(run_last));
					words_checked++;
				end
			end
			if (cfg_valid && cfg_ready)
				t_cap = cfg_data;
			if (in_valid && in_ready)
				transcode_byte(data_byte, first_byte, last_byte);
		end
		in_fire  <= arst_n && in_valid && in_ready;
		out_fire <= arst_n && out_valid && out_ready;
	end

	// ------------------------------------------------------------------
	// Sender: presents the next word on the falling edge, holds it until
	// taken, then idles for the word's gap.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		frame_byte_t fb;
		if (arst_n) begin
			if (in_valid && !in_fire) begin
				// still waiting for the handshake
			end else if (tx_wait > 0) begin
				tx_wait--;
				in_valid <= 1'b0;
			end else if (payload_q.size() != 0 &&
					!(payload_q[0].drain && pending_utf8_q.size() != 0)) begin
				fb = payload_q.pop_front();
				in_valid   <= 1'b1;
				data_byte  <= fb.data;
				first_byte <= fb.first;
				last_byte  <= fb.last;
				tx_wait    = fb.gap;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stall after each word, plus long holds on request.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				rx_wait = rx_burst ? 0 : $urandom_range(0, 4);
			if (rx_holds_done != rx_holds_asked) begin
				rx_holds_done++;
				rx_wait = RX_HOLD_CYCLES;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any word moving on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: no traffic for %0d cycles", $time, IDLE_LIMIT);
			$display("id3_text_to_utf8_transcoder_unit verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers (all called at rising-edge time)
	// ------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] d, input logic f, input logic l);
		frame_byte_t fb;
		fb.data  = d;
		fb.first = f;
		fb.last  = l;
		fb.gap   = tx_burst ? 0 : $urandom_range(0, 4);
		fb.drain = tx_drain_next;
		tx_drain_next = 1'b0;
		payload_q.push_back(fb);
		items_queued++;
	endtask

	function automatic logic [15:0] pick_unit();
		logic [15:0] u;
		int unsigned r;
		r = $urandom_range(0, 15);
		if (r == 0)
			u = 16'h0000;
		else if (r == 1)
			u = 16'($urandom_range(id3u_pkg::SURR_LO, id3u_pkg::SURR_HI));
		else if (r < 6)
			u = 16'($urandom_range(1, id3u_pkg::CP_2B - 1));
		else if (r < 10)
			u = 16'($urandom_range(id3u_pkg::CP_2B, id3u_pkg::CP_3B - 1));
		else begin
			u = 16'($urandom_range(id3u_pkg::CP_3B, 16'hFFFF));
			if (u >= id3u_pkg::SURR_LO && u <= id3u_pkg::SURR_HI)
				u = u + 16'h0800;	// step over the surrogate block
		end
		return u;
	endfunction

	// One ID3 text: encoding word, then content fitting that encoding.
	task automatic queue_text(input bit close);
		logic [7:0]  enc;
		logic [7:0]  body[$];
		logic [15:0] u;
		logic [31:0] rnd;
		bit          be;
		int unsigned kind, nch, i;
		kind = $urandom_range(0, 3);
		case (kind)
		0: enc = id3u_pkg::ENCB_LATIN1;
		1: enc = id3u_pkg::ENCB_UTF8;
		2: enc = id3u_pkg::ENCB_UTF16BE;
		default: begin
			enc = ENCB_UTF16;
			if ($urandom_range(0, 2) == 0) begin
				rnd = $urandom_range(4, 255);	// odd encoding value, still UTF-16
				enc = rnd[7:0];
			end
		end
		endcase
		nch = $urandom_range(0, 10);
		be = (enc == id3u_pkg::ENCB_UTF16BE);
		if (kind < 2) begin
			for (i = 0; i < nch; i++) begin
				rnd = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
				body.push_back(rnd[7:0]);
			end
		end else begin
			if ($urandom_range(0, 1)) begin
				be = 1'($urandom_range(0, 1));
				body.push_back(be ? id3u_pkg::BOM_FE : id3u_pkg::BOM_FF);
				body.push_back(be ? id3u_pkg::BOM_FF : id3u_pkg::BOM_FE);
			end
			for (i = 0; i < nch; i++) begin
				u = pick_unit();
				body.push_back(be ? u[15:8] : u[7:0]);
				body.push_back(be ? u[7:0] : u[15:8]);
			end
			if ($urandom_range(0, 5) == 0) begin
				rnd = $urandom;
				body.push_back(rnd[7:0]);	// lone trailing byte
			end
		end
		queue_byte(enc, 1'b1, close && body.size() == 0);
		for (i = 0; i < body.size(); i++)
			queue_byte(body[i], 1'b0, close && i == body.size() - 1);
		texts_queued++;
	endtask

	task automatic queue_noise(input int unsigned n);
		logic [31:0] rnd;
		int unsigned i;
		for (i = 0; i < n; i++) begin
			rnd = $urandom;
			queue_byte(rnd[7:0], rnd[10:8] == 0, rnd[13:11] == 0);
		end
	endtask

	// everything sent and answered, then let the pipeline settle
	task automatic wait_drained();
		do @(posedge clk);
		while (payload_q.size() != 0 || in_valid || pending_utf8_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [11:0] cap);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [11:0] caps[NUM_PHASES];
		int unsigned p, phase_end;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed, at reset capacity.
		// bytes ahead of any encoding word decode as Latin-1
		queue_byte(8'h41, 1'b0, 1'b0);
		queue_byte(8'hE9, 1'b0, 1'b1);
		// past the last byte: silent, then a repeated terminator
		queue_byte(8'h42, 1'b0, 1'b0);
		queue_byte(8'h43, 1'b0, 1'b1);
		// encoding word that is also the last byte: empty text
		queue_byte(id3u_pkg::ENCB_LATIN1, 1'b1, 1'b1);
		// Latin-1 edges
		queue_byte(id3u_pkg::ENCB_LATIN1, 1'b1, 1'b0);
		queue_byte(8'h7F, 1'b0, 1'b0);
		queue_byte(8'h80, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b1);
		// UTF-8 pass-through, zero byte stops it
		queue_byte(id3u_pkg::ENCB_UTF8, 1'b1, 1'b0);
		queue_byte(8'hC3, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'h41, 1'b0, 1'b1);
		// UTF-16 with FF FE mark, odd byte left at the end
		queue_byte(ENCB_UTF16, 1'b1, 1'b0);
		queue_byte(id3u_pkg::BOM_FF, 1'b0, 1'b0);
		queue_byte(id3u_pkg::BOM_FE, 1'b0, 1'b0);
		queue_byte(8'hE9, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'h55, 1'b0, 1'b1);
		// UTF-16 big-endian default, top unit, then a surrogate
		queue_byte(id3u_pkg::ENCB_UTF16BE, 1'b1, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'hD8, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b1);
		texts_queued += 6;
		wait_drained();

		// Random phases, one capacity each; extremes included.
		caps[0] = 12'd0;
		caps[1] = 12'd1;
		caps[2] = 12'd2;
		caps[3] = 12'd3;
		caps[4] = 12'd4095;
		caps[5] = 12'($urandom_range(4, 16));
		caps[6] = 12'($urandom_range(4, 40));
		caps[7] = 12'($urandom_range(0, 4095));
		caps[8] = id3u_pkg::CAP_RESET;
		for (p = 0; p < NUM_PHASES; p++) begin
			write_capacity(caps[p]);
			tx_burst = (p == 2 || p == 4);	// back-to-back stretches
			rx_burst = (p == 2);
			if (p == 4)
				rx_holds_asked++;	// long output stall while input keeps coming
			// the last text and the open tail overrun the mark
			phase_end = items_queued + (ITEM_TARGET - 25) / NUM_PHASES - TEXT_OVERRUN;
			// tail of a text left open by the previous phase, new capacity
			queue_noise(0);
			queue_byte(8'($urandom_range(1, 255)), 1'b0, 1'b0);
			queue_byte(8'($urandom_range(1, 255)), 1'b0, 1'b0);
			while (items_queued < phase_end) begin
				if (p == 6 && items_queued > phase_end - 20 && drains_asked == 0) begin
					tx_drain_next = 1'b1;
					drains_asked++;
				end
				if ($urandom_range(0, 9) == 0)
					queue_noise($urandom_range(1, 4));
				else
					queue_text(1'b1);
			end
			if ($urandom_range(0, 1))
				queue_text(1'b0);
			wait_drained();
		end

		$display("Sent %0d input words in %0d texts over %0d capacity settings;",
			items_queued, texts_queued, NUM_PHASES + 1);
		$display("checked %0d output words, %0d mismatches.", words_checked, mismatches);
		if (mismatches == 0)
			$display("id3_text_to_utf8_transcoder_unit verification clean");
		else
			$display("id3_text_to_utf8_transcoder_unit verification failed");
		$finish;
	end

endmodule
